// ===== rtl/rtk_pkg.sv =====
// Shared types and constants for the running top-k sum tracker.
// Used by rtk_ctrl, rtk_dp and running_top_k_sum_tracker; depends on nothing.
package rtk_pkg;

  localparam int unsigned SUM_BITS       = 26;
  localparam int unsigned CNT_BITS       = 11;
  localparam int unsigned TOPK_BITS      = 11;
  localparam int unsigned IN_VALUE_BITS  = 16;
  localparam int unsigned DEF_CAPACITY   = 1024;
  localparam int unsigned DEF_VALUE_BITS = 16;

  localparam logic [SUM_BITS-1:0]  SUM_MAX    = '1;
  localparam logic [TOPK_BITS-1:0] TOPK_RESET = TOPK_BITS'(1);

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_SAMPLE = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_ABSENT = 2'd2
  } stat_e;

  // Read address sources of the sorted store
  typedef enum logic [2:0] {
    RD_BND,
    RD_BND2,
    RD_PTRM1,
    RD_PTR,
    RD_PTRP1
  } rd_sel_e;

  typedef struct packed {
    logic    load;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    cap_bnd;
    logic    cap_bnd2;
    logic    wr_en;
    logic    wr_rd;
    logic    ptr_dec;
    logic    ptr_inc;
    logic    commit_ins;
    logic    commit_rem;
    logic    set_full;
    logic    set_absent;
    logic    sweep_acc;
    logic    finish;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       full;
    logic       n_ge_k;
    logic       n_gt_k;
    logic       k_zero;
    logic       ptr_zero;
    logic       ptr_eq_n;
    logic       ptrp1_eq_n;
    logic       rd_gt_v;
    logic       rd_eq_v;
    logic       out_busy;
    logic       sweep_done;
  } sts_t;

endpackage

// ===== rtl/rtk_dp.sv =====
// Datapath of the top-k sum tracker: sorted value store, sums, pointers, output register.
// Depends on rtk_pkg; driven by rtk_ctrl through cmd_t, reports through sts_t.
module rtk_dp #(
  parameter int unsigned CAPACITY   = rtk_pkg::DEF_CAPACITY,
  parameter int unsigned VALUE_BITS = rtk_pkg::DEF_VALUE_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [rtk_pkg::IN_VALUE_BITS-1:0]   in_value_i,
  input  logic [1:0]                          in_req_i,
  input  logic                                cfg_we_i,
  input  logic [rtk_pkg::TOPK_BITS-1:0]       cfg_wdata_i,
  input  logic                                out_ready_i,
  input  rtk_pkg::cmd_t                       cmd_i,
  output rtk_pkg::sts_t                       sts_o,
  output logic                                out_valid_o,
  output logic [63:0]                         out_data_o,
  output logic [1:0]                          out_status_o
);

  localparam int unsigned AW  = $clog2(CAPACITY);
  localparam int unsigned PW  = $clog2(CAPACITY + 1);
  localparam int unsigned CW  = (PW > rtk_pkg::TOPK_BITS) ? PW : rtk_pkg::TOPK_BITS;
  localparam int unsigned SW0 = VALUE_BITS + PW;
  localparam int unsigned SW  = (SW0 > rtk_pkg::SUM_BITS) ? SW0 : rtk_pkg::SUM_BITS;

  logic [VALUE_BITS-1:0] mem_q [CAPACITY];

  logic [PW-1:0]                    cnt_q, cnt_d, ptr_q, ptr_d;
  logic [rtk_pkg::TOPK_BITS-1:0]    topk_q, topk_d, taken_q, taken_d;
  logic [SW-1:0]                    sum_q, sum_d;
  logic [rtk_pkg::SUM_BITS-1:0]     best_q, best_d, sat_sum, best_next;
  logic [VALUE_BITS-1:0]            val_q, rd_q, bnd_q, bnd2_q;
  logic [1:0]                       req_q, stat_q, stat_d;
  logic                             out_valid_q, out_valid_d;
  logic [63:0]                      out_data_q;
  logic [1:0]                       out_status_q;

  logic [VALUE_BITS+rtk_pkg::IN_VALUE_BITS-1:0] in_ext;
  logic [VALUE_BITS-1:0]            in_val;
  logic [CW-1:0]                    cnt_x, k_x, bnd_addr, bnd2_addr;
  logic [PW-1:0]                    ptr_m1, ptr_p1;
  logic [AW-1:0]                    raddr;
  logic [SW-1:0]                    v_s, b_s, b2_s, rd_s;

  assign in_ext = {{VALUE_BITS{1'b0}}, in_value_i};
  assign in_val = in_ext[VALUE_BITS-1:0];

  assign cnt_x     = CW'(cnt_q);
  assign k_x       = CW'(topk_q);
  assign bnd_addr  = cnt_x - k_x;
  assign bnd2_addr = bnd_addr - 1'b1;
  assign ptr_m1    = ptr_q - 1'b1;
  assign ptr_p1    = ptr_q + 1'b1;

  assign v_s  = SW'(val_q);
  assign b_s  = SW'(bnd_q);
  assign b2_s = SW'(bnd2_q);
  assign rd_s = SW'(rd_q);

  always_comb begin
    unique case (cmd_i.rd_sel)
      rtk_pkg::RD_BND:   raddr = bnd_addr[AW-1:0];
      rtk_pkg::RD_BND2:  raddr = bnd2_addr[AW-1:0];
      rtk_pkg::RD_PTRM1: raddr = ptr_m1[AW-1:0];
      rtk_pkg::RD_PTR:   raddr = ptr_q[AW-1:0];
      rtk_pkg::RD_PTRP1: raddr = ptr_p1[AW-1:0];
      default:           raddr = ptr_q[AW-1:0];
    endcase
  end

  // Sorted store, ascending; one read and one write port
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[raddr];
    end
    if (cmd_i.wr_en) begin
      mem_q[ptr_q[AW-1:0]] <= cmd_i.wr_rd ? rd_q : val_q;
    end
  end

  assign sat_sum   = (sum_q > SW'(rtk_pkg::SUM_MAX)) ? rtk_pkg::SUM_MAX
                                                     : sum_q[rtk_pkg::SUM_BITS-1:0];
  assign best_next = (req_q == rtk_pkg::REQ_SAMPLE && sat_sum > best_q) ? sat_sum : best_q;

  always_comb begin
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    topk_d      = topk_q;
    taken_d     = taken_q;
    sum_d       = sum_q;
    best_d      = best_q;
    stat_d      = stat_q;
    out_valid_d = out_ready_i ? 1'b0 : out_valid_q;

    if (cfg_we_i) begin
      topk_d  = cfg_wdata_i;
      sum_d   = '0;
      ptr_d   = cnt_q;
      taken_d = '0;
    end else begin
      if (cmd_i.load) begin
        ptr_d  = (in_req_i == rtk_pkg::REQ_INSERT) ? cnt_q : '0;
        stat_d = rtk_pkg::STAT_OK;
      end
      if (cmd_i.ptr_dec || cmd_i.sweep_acc) begin
        ptr_d = ptr_m1;
      end
      if (cmd_i.ptr_inc) begin
        ptr_d = ptr_p1;
      end
      if (cmd_i.sweep_acc) begin
        sum_d   = sum_q + rd_s;
        taken_d = taken_q + 1'b1;
      end
      if (cmd_i.commit_ins) begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_x < k_x) begin
          sum_d = sum_q + v_s;
        end else if (topk_q != '0 && val_q > bnd_q) begin
          sum_d = sum_q + v_s - b_s;
        end
      end
      if (cmd_i.commit_rem) begin
        cnt_d = cnt_q - 1'b1;
        if (cnt_x <= k_x) begin
          sum_d = sum_q - v_s;
        end else if (topk_q != '0 && val_q >= bnd_q) begin
          sum_d = sum_q - v_s + b2_s;
        end
      end
      if (cmd_i.set_full) begin
        stat_d = rtk_pkg::STAT_FULL;
      end
      if (cmd_i.set_absent) begin
        stat_d = rtk_pkg::STAT_ABSENT;
      end
      if (cmd_i.finish) begin
        best_d      = best_next;
        out_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      ptr_q       <= '0;
      topk_q      <= rtk_pkg::TOPK_RESET;
      taken_q     <= '0;
      sum_q       <= '0;
      best_q      <= '0;
      stat_q      <= rtk_pkg::STAT_OK;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      ptr_q       <= ptr_d;
      topk_q      <= topk_d;
      taken_q     <= taken_d;
      sum_q       <= sum_d;
      best_q      <= best_d;
      stat_q      <= stat_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Item payload and boundary values
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      val_q <= in_val;
      req_q <= in_req_i;
    end
    if (cmd_i.cap_bnd) begin
      bnd_q <= rd_q;
    end
    if (cmd_i.cap_bnd2) begin
      bnd2_q <= rd_q;
    end
    if (cmd_i.finish) begin
      out_data_q   <= {1'b0, cnt_x[rtk_pkg::CNT_BITS-1:0], best_next, sat_sum};
      out_status_q <= stat_q;
    end
  end

  assign sts_o.req        = req_q;
  assign sts_o.full       = (cnt_q == PW'(CAPACITY));
  assign sts_o.n_ge_k     = (cnt_x >= k_x);
  assign sts_o.n_gt_k     = (cnt_x > k_x);
  assign sts_o.k_zero     = (topk_q == '0);
  assign sts_o.ptr_zero   = (ptr_q == '0);
  assign sts_o.ptr_eq_n   = (ptr_q == cnt_q);
  assign sts_o.ptrp1_eq_n = (ptr_p1 == cnt_q);
  assign sts_o.rd_gt_v    = (rd_q > val_q);
  assign sts_o.rd_eq_v    = (rd_q == val_q);
  assign sts_o.out_busy   = out_valid_q && !out_ready_i;
  assign sts_o.sweep_done = (ptr_q == '0) || (taken_q == topk_q);

  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_data_q;
  assign out_status_o = out_status_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= PW'(CAPACITY))
    else $error("active count above capacity");

  a_wr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_en |-> ptr_q < PW'(CAPACITY) && ptr_q <= cnt_q)
    else $error("store write outside the active range");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> !(out_valid_q && !out_ready_i))
    else $error("result overwritten while stalled");

  a_rem_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit_rem |-> cnt_q != '0)
    else $error("remove committed on an empty store");

endmodule

// ===== rtl/rtk_ctrl.sv =====
// Controller of the top-k sum tracker: sequences boundary reads, shifts, searches
// and the sum sweep after a top_count write. Depends on rtk_pkg.
module rtk_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          cfg_we_i,
  input  rtk_pkg::sts_t sts_i,
  output logic          in_ready_o,
  output rtk_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEC,
    S_B1,
    S_B2,
    S_INS_RD,
    S_INS_CMP,
    S_REM_RD,
    S_REM_CMP,
    S_SHF_RD,
    S_SHF_WR,
    S_FIN,
    S_SWP_RD,
    S_SWP_ACC
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.rd_sel = rtk_pkg::RD_PTR;
    in_ready_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DEC;
        end
      end
      S_DEC: begin
        priority if (sts_i.req == rtk_pkg::REQ_INSERT) begin
          if (sts_i.full) begin
            cmd_o.set_full = 1'b1;
            state_d        = S_FIN;
          end else if (sts_i.n_ge_k && !sts_i.k_zero) begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = rtk_pkg::RD_BND;
            state_d      = S_B1;
          end else begin
            state_d = S_INS_RD;
          end
        end else if (sts_i.req == rtk_pkg::REQ_REMOVE) begin
          if (sts_i.n_gt_k && !sts_i.k_zero) begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = rtk_pkg::RD_BND;
            state_d      = S_B1;
          end else begin
            state_d = S_REM_RD;
          end
        end else begin
          state_d = S_FIN;
        end
      end
      S_B1: begin
        cmd_o.cap_bnd = 1'b1;
        if (sts_i.req == rtk_pkg::REQ_REMOVE) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = rtk_pkg::RD_BND2;
          state_d      = S_B2;
        end else begin
          state_d = S_INS_RD;
        end
      end
      S_B2: begin
        cmd_o.cap_bnd2 = 1'b1;
        state_d        = S_REM_RD;
      end
      S_INS_RD: begin
        if (sts_i.ptr_zero) begin
          cmd_o.wr_en      = 1'b1;
          cmd_o.commit_ins = 1'b1;
          state_d          = S_FIN;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = rtk_pkg::RD_PTRM1;
          state_d      = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        cmd_o.wr_en = 1'b1;
        if (sts_i.rd_gt_v) begin
          // move the larger value up one slot
          cmd_o.wr_rd   = 1'b1;
          cmd_o.ptr_dec = 1'b1;
          state_d       = S_INS_RD;
        end else begin
          cmd_o.commit_ins = 1'b1;
          state_d          = S_FIN;
        end
      end
      S_REM_RD: begin
        if (sts_i.ptr_eq_n) begin
          cmd_o.set_absent = 1'b1;
          state_d          = S_FIN;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = rtk_pkg::RD_PTR;
          state_d      = S_REM_CMP;
        end
      end
      S_REM_CMP: begin
        if (sts_i.rd_eq_v) begin
          state_d = S_SHF_RD;
        end else begin
          cmd_o.ptr_inc = 1'b1;
          state_d       = S_REM_RD;
        end
      end
      S_SHF_RD: begin
        if (sts_i.ptrp1_eq_n) begin
          cmd_o.commit_rem = 1'b1;
          state_d          = S_FIN;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = rtk_pkg::RD_PTRP1;
          state_d      = S_SHF_WR;
        end
      end
      S_SHF_WR: begin
        // close the gap left by the removed value
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_rd   = 1'b1;
        cmd_o.ptr_inc = 1'b1;
        state_d       = S_SHF_RD;
      end
      S_FIN: begin
        if (!sts_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_SWP_RD: begin
        if (sts_i.sweep_done) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = rtk_pkg::RD_PTRM1;
          state_d      = S_SWP_ACC;
        end
      end
      S_SWP_ACC: begin
        cmd_o.sweep_acc = 1'b1;
        state_d         = S_SWP_RD;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // a top_count write restarts the sum over the largest values
    if (cfg_we_i) begin
      cmd_o      = '0;
      cmd_o.rd_sel = rtk_pkg::RD_PTR;
      in_ready_o = 1'b0;
      state_d    = S_SWP_RD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == S_IDLE && !cfg_we_i)
    else $error("ready outside idle");

  a_load_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == S_DEC || state_q == S_SWP_RD)
    else $error("accepted item not decoded");

  a_one_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.commit_ins && cmd_o.commit_rem))
    else $error("insert and remove committed together");

endmodule

// ===== rtl/running_top_k_sum_tracker.sv =====
// Top level of the running top-k sum tracker.
// Depends on rtk_pkg, rtk_ctrl and rtk_dp.
//
// Usage:
//   Input stream s_axis: tuser carries req_type (insert, remove, sample),
//   tdata carries item_value. One result per transaction on m_axis:
//   tdata = {pad, active_count, best_sum, top_sum}, tuser = status.
//   cfg_we_i/cfg_wdata_i write top_count; write only while idle. Each write
//   starts a sum over the largest min(top_count, values stored) values.
// Processing (n = values stored, one store access per cycle):
//   sample and insert into a full store: no store access.
//   insert: moves each value above the new one up one slot.
//   remove: searches upward through up to n values, then shifts down.
//   The block takes one item at a time; s_axis_tready rises when the result
//   enters the output register, even if it is not yet taken.
// Reset: store empty, sums zero, top_count one, no sweep needed.
// Stall: a held result keeps the next item's result waiting in the
//   controller until m_axis_tready frees the output register.
module running_top_k_sum_tracker #(
  parameter int unsigned CAPACITY   = rtk_pkg::DEF_CAPACITY,
  parameter int unsigned VALUE_BITS = rtk_pkg::DEF_VALUE_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [15:0]                   s_axis_tdata,   // [15:0] item_value
  input  logic [1:0]                    s_axis_tuser,   // [1:0] req_type
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [25:0] top_sum, [51:26] best_sum, [62:52] active_count, [63] zero
  output logic [63:0]                   m_axis_tdata,
  output logic [1:0]                    m_axis_tuser,   // [1:0] status
  input  logic                          cfg_we_i,
  input  logic [rtk_pkg::TOPK_BITS-1:0] cfg_wdata_i
);

  rtk_pkg::cmd_t cmd;
  rtk_pkg::sts_t sts;

  rtk_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .cfg_we_i   (cfg_we_i),
    .sts_i      (sts),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  rtk_dp #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_value_i   (s_axis_tdata),
    .in_req_i     (s_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .out_ready_i  (m_axis_tready),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid),
    .out_data_o   (m_axis_tdata),
    .out_status_o (m_axis_tuser)
  );

endmodule
